// ===== rtl/core/dcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types, constants and character helpers for the delimited decimal
// command parser.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned INDEX_W = 8;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_STOP_BYTE      = 8'd0;
  localparam logic [INDEX_W-1:0] REG_END_BYTE       = 8'd1;
  localparam logic [INDEX_W-1:0] REG_SEPARATOR_BYTE = 8'd2;
  localparam logic [INDEX_W-1:0] REG_FRAME_LIMIT    = 8'd3;

  // Register reset values
  localparam logic [BYTE_W-1:0] RST_STOP_BYTE      = 8'd27;
  localparam logic [BYTE_W-1:0] RST_END_BYTE       = 8'd13;
  localparam logic [BYTE_W-1:0] RST_SEPARATOR_BYTE = 8'd59;
  localparam logic [BYTE_W-1:0] RST_FRAME_LIMIT    = 8'd64;

  // Result kinds
  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_DROP    = 1'b1;

  // Number of decimal fields kept per frame
  localparam logic [2:0] FIELD_COUNT = 3'd4;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_BLANK  = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } dcp_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] stop_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] separator_byte;
    logic [BYTE_W-1:0] frame_limit;
  } dcp_cfg_t;

  function automatic logic is_blank(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage : dcp_pkg
`default_nettype wire

// ===== rtl/core/dcp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_if
// Valid/ready channels of the command parser: received bytes, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface dcp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [dcp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : dcp_byte_if

interface dcp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [dcp_pkg::BYTE_W-1:0]  command_type;
  logic [dcp_pkg::BYTE_W-1:0]  command_id;
  logic [dcp_pkg::BYTE_W-1:0]  device_number;
  logic [dcp_pkg::VALUE_W-1:0] command_value;

  modport source (output valid, output result_kind, output command_type,
                  output command_id, output device_number, output command_value,
                  input ready);
  modport sink   (input valid, input result_kind, input command_type,
                  input command_id, input device_number, input command_value,
                  output ready);
endinterface : dcp_result_if

interface dcp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dcp_pkg::INDEX_W-1:0] index;
  logic [dcp_pkg::BYTE_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : dcp_cfg_if
`default_nettype wire

// ===== rtl/core/dcp_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_cfg_regs
// Delimiter and frame limit registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module dcp_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  dcp_cfg_if.sink           cfg,
  output dcp_pkg::dcp_cfg_t regs
);
  import dcp_pkg::*;

  dcp_cfg_t regs_q;

  assign cfg.ready = 1'b1;
  assign regs      = regs_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs_q.stop_byte      <= RST_STOP_BYTE;
      regs_q.end_byte       <= RST_END_BYTE;
      regs_q.separator_byte <= RST_SEPARATOR_BYTE;
      regs_q.frame_limit    <= RST_FRAME_LIMIT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STOP_BYTE:      regs_q.stop_byte      <= cfg.data;
        REG_END_BYTE:       regs_q.end_byte       <= cfg.data;
        REG_SEPARATOR_BYTE: regs_q.separator_byte <= cfg.data;
        REG_FRAME_LIMIT:    regs_q.frame_limit    <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule : dcp_cfg_regs
`default_nettype wire

// ===== rtl/core/dcp_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_in_stage
// Input register for received bytes; refills in the cycle the parser takes
// the held item.
// ----------------------------------------------------------------------------
module dcp_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  dcp_byte_if.sink                  rx,
  input  logic                      take,
  output logic                      held_valid,
  output logic [dcp_pkg::BYTE_W-1:0] held_byte
);
  import dcp_pkg::*;

  logic              valid_q;
  logic [BYTE_W-1:0] byte_q;

  assign rx.ready   = !valid_q || take;
  assign held_valid = valid_q;
  assign held_byte  = byte_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (rx.ready) begin
      valid_q <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      byte_q <= rx.rx_byte;
    end
  end

endmodule : dcp_in_stage
`default_nettype wire

// ===== rtl/core/dcp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_parser
// Frame and field parse state, updated once per byte, and the result
// register.
// ----------------------------------------------------------------------------
module dcp_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  dcp_pkg::dcp_cfg_t          regs,
  input  logic                       held_valid,
  input  logic [dcp_pkg::BYTE_W-1:0] held_byte,
  output logic                       take,
  dcp_result_if.source               result
);
  import dcp_pkg::*;

  // Parse state
  logic [BYTE_W-1:0]  byte_count, byte_count_next;
  logic [2:0]         field_index, field_index_next;
  dcp_phase_t         field_phase, field_phase_next;
  logic               negative_flag, negative_flag_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [BYTE_W-1:0]  fld_type, fld_type_next;
  logic [BYTE_W-1:0]  fld_id, fld_id_next;
  logic [BYTE_W-1:0]  fld_dev, fld_dev_next;
  logic [VALUE_W-1:0] fld_value, fld_value_next;

  // Field values and index as they stand once the open field is closed
  logic [VALUE_W-1:0] closed;
  logic [2:0]         cl_index;
  logic [BYTE_W-1:0]  cl_type, cl_id, cl_dev;
  logic [VALUE_W-1:0] cl_value;

  logic [3:0]         digit;
  logic [VALUE_W-1:0] times_ten;

  logic               emit;
  logic               res_kind;
  logic [BYTE_W-1:0]  res_type, res_id, res_dev;
  logic [VALUE_W-1:0] res_value;

  // Result register
  logic               out_valid;
  logic               out_kind;
  logic [BYTE_W-1:0]  out_type, out_id, out_dev;
  logic [VALUE_W-1:0] out_value;

  assign take = held_valid && (!out_valid || result.ready);

  assign digit     = 4'(held_byte - CH_ZERO);
  // acc * 10 as (acc << 3) + (acc << 1), wrapping at 16 bits
  assign times_ten = {accumulator[VALUE_W-4:0], 3'b000} + {accumulator[VALUE_W-2:0], 1'b0};

  always_comb begin
    closed   = negative_flag ? VALUE_W'(16'd0 - accumulator) : accumulator;
    cl_index = field_index;
    cl_type  = fld_type;
    cl_id    = fld_id;
    cl_dev   = fld_dev;
    cl_value = fld_value;
    if (field_index < FIELD_COUNT) begin
      cl_index = field_index + 3'd1;
      case (field_index[1:0])
        2'd0:    cl_type  = closed[BYTE_W-1:0];
        2'd1:    cl_id    = closed[BYTE_W-1:0];
        2'd2:    cl_dev   = closed[BYTE_W-1:0];
        default: cl_value = closed;
      endcase
    end
  end

  always_comb begin
    byte_count_next    = byte_count;
    field_index_next   = field_index;
    field_phase_next   = field_phase;
    negative_flag_next = negative_flag;
    accumulator_next   = accumulator;
    fld_type_next      = fld_type;
    fld_id_next        = fld_id;
    fld_dev_next       = fld_dev;
    fld_value_next     = fld_value;
    emit               = 1'b0;
    res_kind           = KIND_COMMAND;
    res_type           = '0;
    res_id             = '0;
    res_dev            = '0;
    res_value          = '0;

    if (held_byte == regs.stop_byte || held_byte == regs.end_byte) begin
      if (held_byte == regs.end_byte && held_byte != regs.stop_byte) begin
        emit = 1'b1;
        if (byte_count != '0) begin
          res_type  = cl_type;
          res_id    = cl_id;
          res_dev   = cl_dev;
          res_value = cl_value;
        end else begin
          res_type  = fld_type;
          res_id    = fld_id;
          res_dev   = fld_dev;
          res_value = fld_value;
        end
      end
      byte_count_next    = '0;
      field_index_next   = '0;
      field_phase_next   = PH_BLANK;
      negative_flag_next = 1'b0;
      accumulator_next   = '0;
      fld_type_next      = '0;
      fld_id_next        = '0;
      fld_dev_next       = '0;
      fld_value_next     = '0;
    end else if (byte_count >= regs.frame_limit) begin
      // frame full: byte dropped, frame kept
      emit     = 1'b1;
      res_kind = KIND_DROP;
    end else begin
      byte_count_next = byte_count + 8'd1;
      // first byte of a frame is a flag and is not parsed
      if (byte_count != '0) begin
        if (held_byte == regs.separator_byte) begin
          field_index_next   = cl_index;
          fld_type_next      = cl_type;
          fld_id_next        = cl_id;
          fld_dev_next       = cl_dev;
          fld_value_next     = cl_value;
          field_phase_next   = PH_BLANK;
          negative_flag_next = 1'b0;
          accumulator_next   = '0;
        end else if (field_index < FIELD_COUNT) begin
          unique case (field_phase)
            PH_BLANK: begin
              if (is_blank(held_byte)) begin
                field_phase_next = PH_BLANK;
              end else if (held_byte == CH_PLUS) begin
                field_phase_next = PH_DIGITS;
              end else if (held_byte == CH_MINUS) begin
                negative_flag_next = 1'b1;
                field_phase_next   = PH_DIGITS;
              end else if (is_digit(held_byte)) begin
                accumulator_next = VALUE_W'(digit);
                field_phase_next = PH_DIGITS;
              end else begin
                field_phase_next = PH_DONE;
              end
            end
            PH_DIGITS: begin
              if (is_digit(held_byte)) begin
                accumulator_next = times_ten + VALUE_W'(digit);
              end else begin
                field_phase_next = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      field_index   <= '0;
      field_phase   <= PH_BLANK;
      negative_flag <= 1'b0;
      accumulator   <= '0;
      fld_type      <= '0;
      fld_id        <= '0;
      fld_dev       <= '0;
      fld_value     <= '0;
    end else if (take) begin
      byte_count    <= byte_count_next;
      field_index   <= field_index_next;
      field_phase   <= field_phase_next;
      negative_flag <= negative_flag_next;
      accumulator   <= accumulator_next;
      fld_type      <= fld_type_next;
      fld_id        <= fld_id_next;
      fld_dev       <= fld_dev_next;
      fld_value     <= fld_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_kind  <= res_kind;
      out_type  <= res_type;
      out_id    <= res_id;
      out_dev   <= res_dev;
      out_value <= res_value;
    end
  end

  assign result.valid         = out_valid;
  assign result.result_kind   = out_kind;
  assign result.command_type  = out_type;
  assign result.command_id    = out_id;
  assign result.device_number = out_dev;
  assign result.command_value = out_value;

endmodule : dcp_parser
`default_nettype wire

// ===== rtl/core/delimited_decimal_command_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_decimal_command_parser
// Parses delimited decimal command frames from a received byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while results are taken, and returns at
// most one result item per byte: a command on the end byte, or a drop flag for a
// byte that arrives with the frame full. A byte is held in the input register
// until the parser takes it, and the parse state and the result register are
// updated from it when it is taken; the per-byte parse step (multiply by ten and
// add into a 16-bit accumulator) is combinational. While a result waits to be
// taken the input register can still take one byte, then the input stalls until
// the result is accepted. Configuration writes are always ready and take effect
// on the next byte.
// ----------------------------------------------------------------------------
module delimited_decimal_command_parser (
  input  logic          clk,
  input  logic          rst,
  dcp_byte_if.sink      rx,
  dcp_result_if.source  result,
  dcp_cfg_if.sink       cfg
);
  import dcp_pkg::*;

  dcp_cfg_t          regs;
  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              take;

  dcp_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dcp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  dcp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .take       (take),
    .result     (result)
  );

endmodule : delimited_decimal_command_parser
`default_nettype wire

// ===== tb/sv/dcp_command_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_command_checker
// Watches the byte, result and configuration channels of the command parser.
// It keeps its own copy of the registers and the frame parse state, predicts
// the result item, if any, of every accepted byte, and compares each accepted
// result with the oldest prediction.
// ----------------------------------------------------------------------------
module dcp_command_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rx_valid,
  input  logic                        rx_ready,
  input  logic [dcp_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                        res_valid,
  input  logic                        res_ready,
  input  logic                        res_kind,
  input  logic [dcp_pkg::BYTE_W-1:0]  res_type,
  input  logic [dcp_pkg::BYTE_W-1:0]  res_id,
  input  logic [dcp_pkg::BYTE_W-1:0]  res_device,
  input  logic [dcp_pkg::VALUE_W-1:0] res_value,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [dcp_pkg::INDEX_W-1:0] cfg_index,
  input  logic [dcp_pkg::BYTE_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          commands_seen,
  output int                          drops_seen
);
  import dcp_pkg::*;

  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  ctype;
    logic [BYTE_W-1:0]  cid;
    logic [BYTE_W-1:0]  device;
    logic [VALUE_W-1:0] value;
  } cmd_result_t;

  cmd_result_t expected_cmds[$];

  dcp_cfg_t           regs;
  logic [BYTE_W-1:0]  frame_bytes;
  logic [2:0]         field_idx;
  dcp_phase_t         phase;
  logic               minus;
  logic [VALUE_W-1:0] acc;
  logic [VALUE_W-1:0] fields [4];

  function automatic logic is_space_char(input logic [BYTE_W-1:0] b);
    case (b)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_frame_state();
    frame_bytes = '0;
    field_idx   = '0;
    phase       = PH_BLANK;
    minus       = 1'b0;
    acc         = '0;
    for (int i = 0; i < 4; i++) fields[i] = '0;
  endtask

  task automatic close_current_field();
    if (field_idx < FIELD_COUNT) begin
      fields[field_idx] = minus ? (VALUE_W'(0) - acc) : acc;
      field_idx = field_idx + 3'd1;
    end
    phase = PH_BLANK;
    minus = 1'b0;
    acc   = '0;
  endtask

  task automatic parse_char(input logic [BYTE_W-1:0] b);
    logic is_num;
    is_num = (b >= CH_ZERO) && (b <= CH_NINE);
    if (b == regs.separator_byte) begin
      close_current_field();
    end else if (field_idx < FIELD_COUNT) begin
      case (phase)
        PH_BLANK: begin
          if (is_space_char(b)) begin
            // leading whitespace is skipped
          end else if (b == CH_PLUS) begin
            phase = PH_DIGITS;
          end else if (b == CH_MINUS) begin
            minus = 1'b1;
            phase = PH_DIGITS;
          end else if (is_num) begin
            acc   = VALUE_W'(b - CH_ZERO);
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_num) acc = VALUE_W'(acc * 10) + VALUE_W'(b - CH_ZERO);
          else phase = PH_DONE;
        end
        default: ;
      endcase
    end
  endtask

  task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
    cmd_result_t r;
    r = '0;
    if (b == regs.stop_byte) begin
      clear_frame_state();
    end else if (b == regs.end_byte) begin
      if (frame_bytes != 0) close_current_field();
      r.kind   = KIND_COMMAND;
      r.ctype  = fields[0][BYTE_W-1:0];
      r.cid    = fields[1][BYTE_W-1:0];
      r.device = fields[2][BYTE_W-1:0];
      r.value  = fields[3];
      expected_cmds.push_back(r);
      clear_frame_state();
    end else if (frame_bytes >= regs.frame_limit) begin
      // frame full: byte dropped, frame kept
      r.kind = KIND_DROP;
      expected_cmds.push_back(r);
    end else begin
      // first byte of a frame is a flag and is not parsed
      if (frame_bytes != 0) parse_char(b);
      frame_bytes = frame_bytes + 8'd1;
    end
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cmd_result_t want;
    if (rst) begin
      regs.stop_byte      = RST_STOP_BYTE;
      regs.end_byte       = RST_END_BYTE;
      regs.separator_byte = RST_SEPARATOR_BYTE;
      regs.frame_limit    = RST_FRAME_LIMIT;
      clear_frame_state();
      expected_cmds.delete();
      fail_count    = 0;
      pending       = 0;
      commands_seen = 0;
      drops_seen    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STOP_BYTE:      regs.stop_byte      = cfg_data;
          REG_END_BYTE:       regs.end_byte       = cfg_data;
          REG_SEPARATOR_BYTE: regs.separator_byte = cfg_data;
          REG_FRAME_LIMIT:    regs.frame_limit    = cfg_data;
          default: ;
        endcase
      end
      if (rx_valid && rx_ready) parse_rx_byte(rx_byte);
      if (res_valid && res_ready) begin
        if (res_kind == KIND_DROP) drops_seen++;
        else commands_seen++;
        if (expected_cmds.size() == 0) begin
          $display("%0t ns: unexpected result item, expected none, actual kind %0d",
                   $time, res_kind);
          fail_count++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("result_kind", VALUE_W'(want.kind), VALUE_W'(res_kind));
          check_field("command_type", VALUE_W'(want.ctype), VALUE_W'(res_type));
          check_field("command_id", VALUE_W'(want.cid), VALUE_W'(res_id));
          check_field("device_number", VALUE_W'(want.device), VALUE_W'(res_device));
          check_field("command_value", want.value, res_value);
        end
      end
      pending = expected_cmds.size();
    end
  end

endmodule : dcp_command_checker

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the delimited decimal command parser: directed frames for the
// corner cases, then random well-formed, broken and noise frames across
// several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import dcp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  dcp_byte_if   rx_if ();
  dcp_result_if res_if ();
  dcp_cfg_if    cfg_if ();

  delimited_decimal_command_parser dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  int fail_count;
  int pending;
  int commands_seen;
  int drops_seen;

  dcp_command_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .rx_valid      (rx_if.valid),
    .rx_ready      (rx_if.ready),
    .rx_byte       (rx_if.rx_byte),
    .res_valid     (res_if.valid),
    .res_ready     (res_if.ready),
    .res_kind      (res_if.result_kind),
    .res_type      (res_if.command_type),
    .res_id        (res_if.command_id),
    .res_device    (res_if.device_number),
    .res_value     (res_if.command_value),
    .cfg_valid     (cfg_if.valid),
    .cfg_ready     (cfg_if.ready),
    .cfg_index     (cfg_if.index),
    .cfg_data      (cfg_if.data),
    .fail_count    (fail_count),
    .pending       (pending),
    .commands_seen (commands_seen),
    .drops_seen    (drops_seen)
  );

  logic     no_idle = 1'b0;
  dcp_cfg_t cur;
  int       bytes_sent  = 0;
  int       settings_run = 1;
  int       quiet_cycles;

  initial begin
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
  end

  always @(negedge clk) begin
    res_if.ready <= !rst && (no_idle || $urandom_range(0, 99) >= 37);
  end

  // ends the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired at %0t ns with %0d results outstanding", $time, pending);
        $display("FAIL delimited_decimal_command_parser");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      rx_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // sender holds off until all results are back and the pipe has emptied
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] stop_b, input logic [BYTE_W-1:0] end_b,
                            input logic [BYTE_W-1:0] sep_b, input logic [BYTE_W-1:0] limit);
    wait_idle();
    write_reg(REG_STOP_BYTE, stop_b);
    write_reg(REG_END_BYTE, end_b);
    write_reg(REG_SEPARATOR_BYTE, sep_b);
    write_reg(REG_FRAME_LIMIT, limit);
    cur.stop_byte      = stop_b;
    cur.end_byte       = end_b;
    cur.separator_byte = sep_b;
    cur.frame_limit    = limit;
    settings_run++;
  endtask

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cur.stop_byte || b == cur.end_byte || b == cur.separator_byte);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] blank_byte();
    logic [BYTE_W-1:0] b;
    case ($urandom_range(0, 5))
      0: b = 8'h09;
      1: b = 8'h0A;
      2: b = 8'h0B;
      3: b = 8'h0C;
      4: b = 8'h0D;
      default: b = 8'h20;
    endcase
    if (b == cur.stop_byte || b == cur.end_byte) b = 8'h20;
    return b;
  endfunction

  task automatic send_frame();
    int nfields;
    int ndigits;
    send_byte(plain_byte());
    nfields = $urandom_range(0, 6);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) send_byte(cur.separator_byte);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_byte(blank_byte());
      case ($urandom_range(0, 3))
        0: send_byte(CH_PLUS);
        1: send_byte(CH_MINUS);
        default: ;
      endcase
      ndigits = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      repeat (ndigits) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 7) == 0) send_byte(plain_byte());
      // padding that may overrun the frame
      if ($urandom_range(0, 11) == 0) repeat ($urandom_range(1, 20)) send_byte(plain_byte());
      // aborted frame
      if ($urandom_range(0, 39) == 0) send_byte(cur.stop_byte);
    end
    send_byte(cur.end_byte);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
    if ($urandom_range(0, 1) == 0) send_byte(cur.end_byte);
  endtask

  task automatic run_random(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if ($urandom_range(0, 99) < 15) send_noise();
      else send_frame();
    end
  endtask

  initial begin
    cur.stop_byte      = RST_STOP_BYTE;
    cur.end_byte       = RST_END_BYTE;
    cur.separator_byte = RST_SEPARATOR_BYTE;
    cur.frame_limit    = RST_FRAME_LIMIT;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: empty frame, extremes, signs, whitespace, wrap, extra fields
    send_byte(cur.end_byte);
    send_text("F255;-1;\t+70000;65535;9");
    send_byte(cur.end_byte);
    send_text("F-;x7");
    send_byte(cur.end_byte);
    send_text("F12;3");
    send_byte(cur.stop_byte);
    send_text("F9");
    send_byte(cur.end_byte);
    wait_idle();
    run_random(100);

    set_config(8'h00, "\n", ",", 8'd255);
    no_idle = 1'b1;
    run_random(100);
    no_idle = 1'b0;

    // one-byte frames: only the flag fits
    set_config(8'hFF, 8'h00, " ", 8'd1);
    send_text("F1 2");
    send_byte(cur.end_byte);
    run_random(80);

    set_config(RST_STOP_BYTE, RST_END_BYTE, RST_SEPARATOR_BYTE, 8'd0);
    send_text("ab");
    send_byte(cur.end_byte);
    run_random(30);

    set_config("#", "!", ":", 8'd12);
    send_text("F1:2:3:456789");
    send_byte(cur.end_byte);
    run_random(120);

    set_config(8'd13, 8'd27, 8'hFF, 8'd64);
    run_random(120);

    wait_idle();
    repeat (10) @(negedge clk);
    $display("Sent %0d bytes under %0d register settings; checked %0d commands and %0d drops.",
             bytes_sent, settings_run, commands_seen, drops_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS delimited_decimal_command_parser");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("FAIL delimited_decimal_command_parser");
    end
    $finish;
  end

endmodule : testbench
